// ===== src/spmv_pkg.sv =====
// ----------------------------------------------------------------------------
// spmv_pkg
// shared types and constants of the meeting-vertex shortest path block
// ----------------------------------------------------------------------------
package spmv_pkg;

    localparam int DEF_MAX_VERTICES = 256;
    localparam int DEF_MAX_EDGES    = 1024;
    localparam int DEF_WEIGHT_BITS  = 16;

    localparam int VERT_W  = 8;
    localparam int DIST_W  = 24;
    localparam int SUM_W   = 26;
    localparam int VCNT_W  = 9;
    localparam int KIND_W  = 2;
    localparam int IN_W    = 48;
    localparam int OUT_W   = 32;

    localparam logic [DIST_W-1:0] DIST_INF = '1;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD   = 2'd0,
        KIND_QUERY = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef struct packed {
        logic load_edge;
        logic clear_store;
        logic start_query;
        logic pass_init;
        logic scan_start;
        logic scan_rd;
        logic scan_cmp;
        logic settle;
        logic edge_rd;
        logic edge_chk;
        logic edge_upd;
        logic acc_start;
        logic acc_rd;
        logic acc_wr;
        logic next_pass;
        logic fin_start;
        logic fin_rd;
        logic fin_cmp;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic v_end;
        logic e_end;
        logic best_none;
        logic edge_hit;
        logic last_pass;
        logic out_busy;
    } status_t;

endpackage

// ===== src/spmv_ctrl.sv =====
// ----------------------------------------------------------------------------
// spmv_ctrl
// sequencer for edge loads, store clears and the four shortest path passes of a query
// ----------------------------------------------------------------------------
module spmv_ctrl
    import spmv_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [KIND_W-1:0]   in_kind,
    output logic                in_ready,
    input  status_t             status,
    output cmd_t                cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PASS_INIT,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_EDGE_RD,
        ST_EDGE_CHK,
        ST_EDGE_UPD,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_FIN_RD,
        ST_FIN_CMP,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;

    assign in_ready = ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && ready_reg)
                begin
                    unique case (kind_t'(in_kind))
                        KIND_ADD:   cmd.load_edge = 1'b1;
                        KIND_CLEAR: cmd.clear_store = 1'b1;
                        KIND_QUERY:
                        begin
                            cmd.start_query = 1'b1;
                            state_next      = ST_PASS_INIT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PASS_INIT:
            begin
                cmd.pass_init = 1'b1;
                state_next    = ST_SCAN_RD;
            end
            ST_SCAN_RD:
            begin
                if (!status.v_end)
                begin
                    cmd.scan_rd = 1'b1;
                    state_next  = ST_SCAN_CMP;
                end
                else if (status.best_none)
                begin
                    cmd.acc_start = 1'b1;
                    state_next    = ST_ACC_RD;
                end
                else
                begin
                    cmd.settle = 1'b1;
                    state_next = ST_EDGE_RD;
                end
            end
            ST_SCAN_CMP:
            begin
                cmd.scan_cmp = 1'b1;
                state_next   = ST_SCAN_RD;
            end
            ST_EDGE_RD:
            begin
                if (status.e_end)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN_RD;
                end
                else
                begin
                    cmd.edge_rd = 1'b1;
                    state_next  = ST_EDGE_CHK;
                end
            end
            ST_EDGE_CHK:
            begin
                cmd.edge_chk = 1'b1;
                state_next   = status.edge_hit ? ST_EDGE_UPD : ST_EDGE_RD;
            end
            ST_EDGE_UPD:
            begin
                cmd.edge_upd = 1'b1;
                state_next   = ST_EDGE_RD;
            end
            ST_ACC_RD:
            begin
                if (!status.v_end)
                begin
                    cmd.acc_rd = 1'b1;
                    state_next = ST_ACC_WR;
                end
                else if (status.last_pass)
                begin
                    cmd.fin_start = 1'b1;
                    state_next    = ST_FIN_RD;
                end
                else
                begin
                    cmd.next_pass = 1'b1;
                    state_next    = ST_PASS_INIT;
                end
            end
            ST_ACC_WR:
            begin
                cmd.acc_wr = 1'b1;
                state_next = ST_ACC_RD;
            end
            ST_FIN_RD:
            begin
                if (!status.v_end)
                begin
                    cmd.fin_rd = 1'b1;
                    state_next = ST_FIN_CMP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FIN_CMP:
            begin
                cmd.fin_cmp = 1'b1;
                state_next  = ST_FIN_RD;
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

endmodule

// ===== src/spmv_dp.sv =====
// ----------------------------------------------------------------------------
// spmv_dp
// edge store, distance and sum memories, counters and output word register
// ----------------------------------------------------------------------------
module spmv_dp
    import spmv_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES,
    parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [VCNT_W-1:0]   cfg_data,
    input  logic [VERT_W-1:0]   edge_from,
    input  logic [VERT_W-1:0]   edge_to,
    input  logic [15:0]         edge_weight,
    input  logic [VERT_W-1:0]   source_vertex,
    input  logic [VERT_W-1:0]   destination_vertex,
    input  cmd_t                cmd,
    output status_t             status,
    input  logic                out_ready,
    output logic                out_valid,
    output logic                found,
    output logic [SUM_W-1:0]    best_sum,
    output logic                store_full
);

    localparam int VIW = $clog2(MAX_VERTICES);
    localparam int VCW = $clog2(MAX_VERTICES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam int NDW = 34;

    // edge store
    logic [VERT_W-1:0]      tail_mem [MAX_EDGES];
    logic [VERT_W-1:0]      head_mem [MAX_EDGES];
    logic [WEIGHT_BITS-1:0] cost_mem [MAX_EDGES];
    logic [VERT_W-1:0]      tail_q;
    logic [VERT_W-1:0]      head_q;
    logic [WEIGHT_BITS-1:0] cost_q;

    // per-vertex stores
    logic [DIST_W-1:0]      dist_mem [MAX_VERTICES];
    logic [SUM_W-1:0]       sum_mem  [MAX_VERTICES];
    logic [DIST_W-1:0]      dist_q;
    logic [SUM_W-1:0]       sum_q;
    logic                   dist_ok_q;
    logic [MAX_VERTICES-1:0] dist_ok_reg;
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [MAX_VERTICES-1:0] reached_reg;

    logic [VCNT_W-1:0]      vcount_reg;
    logic [EW-1:0]          count_reg;
    logic                   dropped_reg;
    logic [VCW-1:0]         n_reg;
    logic [VERT_W-1:0]      src_reg;
    logic [VERT_W-1:0]      dst_reg;
    logic [1:0]             pass_reg;
    logic [VCW-1:0]         v_reg;
    logic [EW-1:0]          e_reg;
    logic [VIW-1:0]         best_reg;
    logic                   best_none_reg;
    logic [DIST_W-1:0]      best_d_reg;
    logic [VIW-1:0]         to_reg;
    logic [WEIGHT_BITS-1:0] cost_reg;
    logic                   fin_found_reg;
    logic [SUM_W-1:0]       fin_sum_reg;
    logic                   out_valid_reg;
    logic                   out_found_reg;
    logic [SUM_W-1:0]       out_sum_reg;
    logic                   out_full_reg;

    logic [31:0]            w32;
    logic [31:0]            start32;
    logic [31:0]            from32;
    logic [31:0]            to32;
    logic [31:0]            v32;
    logic [31:0]            cnt32;
    logic [VIW-1:0]         v_idx;
    logic [VIW-1:0]         start_idx;
    logic [VIW-1:0]         to_idx;
    logic [VERT_W-1:0]      start_v;
    logic [VERT_W-1:0]      from_v;
    logic [VERT_W-1:0]      to_v;
    logic [DIST_W-1:0]      dist_val;
    logic [NDW-1:0]         nd_raw;
    logic [DIST_W-1:0]      nd;
    logic                   hit;
    logic                   start_ok;
    logic [VCW-1:0]         n_next;
    logic [VIW-1:0]         dist_raddr;

    assign w32       = 32'(edge_weight);
    assign start_v   = pass_reg[0] ? dst_reg : src_reg;
    assign start32   = 32'(start_v);
    assign start_idx = start32[VIW-1:0];
    assign start_ok  = start32 < 32'(n_reg);
    assign from_v    = pass_reg[1] ? head_q : tail_q;
    assign to_v      = pass_reg[1] ? tail_q : head_q;
    assign from32    = 32'(from_v);
    assign to32      = 32'(to_v);
    assign to_idx    = to32[VIW-1:0];
    assign v32       = 32'(v_reg);
    assign v_idx     = v_reg[VIW-1:0];
    assign cnt32     = 32'(count_reg);
    assign hit       = (from32 == 32'(best_reg)) && (to32 < 32'(n_reg));
    assign dist_val  = dist_ok_q ? dist_q : DIST_INF;
    assign nd_raw    = NDW'(best_d_reg) + NDW'(cost_reg);
    assign nd        = (nd_raw >= NDW'(DIST_INF)) ? DIST_INF : nd_raw[DIST_W-1:0];
    assign n_next    = (32'(vcount_reg) > 32'(MAX_VERTICES)) ? VCW'(MAX_VERTICES)
                                                              : VCW'(vcount_reg);
    assign dist_raddr = cmd.edge_chk ? to_idx : v_idx;

    assign status.v_end     = (v_reg == n_reg);
    assign status.e_end     = (e_reg == count_reg);
    assign status.best_none = best_none_reg;
    assign status.edge_hit  = hit;
    assign status.last_pass = (pass_reg == 2'd3);
    assign status.out_busy  = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign found      = out_found_reg;
    assign best_sum   = out_sum_reg;
    assign store_full = out_full_reg;

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.load_edge && (cnt32 < 32'(MAX_EDGES)))
        begin
            tail_mem[count_reg[EAW-1:0]] <= edge_from;
            head_mem[count_reg[EAW-1:0]] <= edge_to;
            cost_mem[count_reg[EAW-1:0]] <= w32[WEIGHT_BITS-1:0];
        end
        tail_q <= tail_mem[e_reg[EAW-1:0]];
        head_q <= head_mem[e_reg[EAW-1:0]];
        cost_q <= cost_mem[e_reg[EAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pass_init && start_ok)
        begin
            dist_mem[start_idx] <= '0;
        end
        else if (cmd.edge_upd && (nd < dist_val))
        begin
            dist_mem[to_reg] <= nd;
        end
        dist_q <= dist_mem[dist_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_wr && (dist_val != DIST_INF))
        begin
            sum_mem[v_idx] <= ((pass_reg == 2'd0) ? '0 : sum_q) + SUM_W'(dist_val);
        end
        sum_q <= sum_mem[v_idx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.edge_chk)
        begin
            to_reg   <= to_idx;
            cost_reg <= cost_q;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg    <= VCNT_W'(256);
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            n_reg         <= '0;
            src_reg       <= '0;
            dst_reg       <= '0;
            pass_reg      <= '0;
            v_reg         <= '0;
            e_reg         <= '0;
            best_reg      <= '0;
            best_none_reg <= 1'b1;
            best_d_reg    <= DIST_INF;
            dist_ok_q     <= 1'b0;
            dist_ok_reg   <= '0;
            visited_reg   <= '0;
            reached_reg   <= '0;
            fin_found_reg <= 1'b0;
            fin_sum_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_found_reg <= 1'b0;
            out_sum_reg   <= '0;
            out_full_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                vcount_reg <= cfg_data;
            end
            if (cmd.load_edge)
            begin
                if (cnt32 < 32'(MAX_EDGES))
                    count_reg <= count_reg + 1'b1;
                else
                    dropped_reg <= 1'b1;
            end
            if (cmd.clear_store)
            begin
                count_reg   <= '0;
                dropped_reg <= 1'b0;
            end
            if (cmd.start_query)
            begin
                n_reg       <= n_next;
                src_reg     <= source_vertex;
                dst_reg     <= destination_vertex;
                pass_reg    <= '0;
                reached_reg <= '1;
            end
            if (cmd.next_pass)
            begin
                pass_reg <= pass_reg + 1'b1;
            end

            dist_ok_q <= dist_ok_reg[dist_raddr];
            if (cmd.pass_init)
            begin
                dist_ok_reg <= start_ok ? (MAX_VERTICES'(1) << start_idx) : '0;
                visited_reg <= '0;
            end
            if (cmd.edge_upd && (nd < dist_val))
            begin
                dist_ok_reg[to_reg] <= 1'b1;
            end

            if (cmd.pass_init || cmd.scan_start || cmd.acc_start || cmd.fin_start)
            begin
                v_reg <= '0;
            end
            if (cmd.pass_init || cmd.scan_start)
            begin
                best_none_reg <= 1'b1;
                best_d_reg    <= DIST_INF;
            end
            if (cmd.scan_cmp || cmd.acc_wr || cmd.fin_cmp)
            begin
                v_reg <= v_reg + 1'b1;
            end
            if (cmd.scan_cmp && !visited_reg[v_idx] && (dist_val < best_d_reg))
            begin
                best_d_reg    <= dist_val;
                best_reg      <= v_idx;
                best_none_reg <= 1'b0;
            end
            if (cmd.settle)
            begin
                visited_reg[best_reg] <= 1'b1;
                e_reg                 <= '0;
            end
            if ((cmd.edge_chk && !hit) || cmd.edge_upd)
            begin
                e_reg <= e_reg + 1'b1;
            end
            if (cmd.acc_wr && (dist_val == DIST_INF))
            begin
                reached_reg[v_idx] <= 1'b0;
            end

            if (cmd.fin_start)
            begin
                fin_found_reg <= 1'b0;
                fin_sum_reg   <= '0;
            end
            if (cmd.fin_cmp && (v32 != 32'(src_reg)) && (v32 != 32'(dst_reg))
                && reached_reg[v_idx] && (!fin_found_reg || (sum_q < fin_sum_reg)))
            begin
                fin_found_reg <= 1'b1;
                fin_sum_reg   <= sum_q;
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                out_found_reg <= fin_found_reg;
                out_sum_reg   <= fin_sum_reg;
                out_full_reg  <= dropped_reg;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== src/shortest_path_meeting_vertex.sv =====
// edge add and store clear produce no result word
// a query runs four passes; each pass inits the start vertex, then repeats a nearest-vertex
// scan and, for each settled vertex, a walk of the edge store that relaxes every in-range
// edge leaving it, and ends by folding distances into sums; a final scan then picks the result
// one item at a time: the single read port of the distance memory bounds the pass loops
// reset: vertex_count 256, edge store empty, overflow flag clear, no clearing pass
// ----------------------------------------------------------------------------
// shortest_path_meeting_vertex
// least four-way shortest path sum through a meeting vertex over an edge store
// ----------------------------------------------------------------------------
module shortest_path_meeting_vertex
    import spmv_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES,
    parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [VCNT_W-1:0]   cfg_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // edge_from, edge_to, edge_weight, source_vertex, destination_vertex
    input  logic [IN_W-1:0]     s_axis_tdata,
    // kind
    input  logic [KIND_W-1:0]   s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // best_sum, store_full, zero pad
    output logic [OUT_W-1:0]    m_axis_tdata,
    // found
    output logic [0:0]          m_axis_tuser
);

    cmd_t              cmd;
    status_t           status;
    logic              out_found;
    logic [SUM_W-1:0]  out_sum;
    logic              out_full;

    assign cfg_ready = 1'b1;

    spmv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_kind  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    spmv_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_data           (cfg_data),
        .edge_from          (s_axis_tdata[7:0]),
        .edge_to            (s_axis_tdata[15:8]),
        .edge_weight        (s_axis_tdata[31:16]),
        .source_vertex      (s_axis_tdata[39:32]),
        .destination_vertex (s_axis_tdata[47:40]),
        .cmd                (cmd),
        .status             (status),
        .out_ready          (m_axis_tready),
        .out_valid          (m_axis_tvalid),
        .found              (out_found),
        .best_sum           (out_sum),
        .store_full         (out_full)
    );

    assign m_axis_tdata = {{(OUT_W - SUM_W - 1){1'b0}}, out_full, out_sum};
    assign m_axis_tuser = out_found;

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command");

    a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(cmd.emit))
        else $error("result word without emit");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[SUM_W-1:0] == '0))
        else $error("nonzero sum on not-found word");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan_rd || cmd.edge_rd || cmd.acc_rd || cmd.fin_rd) |-> !s_axis_tready)
        else $error("input accepted during a query");

endmodule
